// ===== sv/status_led_blink_sequencer_unit_assert.svh =====
// assertion macros shared by the rtl files
`ifndef STATUS_LED_BLINK_SEQUENCER_UNIT_ASSERT_SVH
`define STATUS_LED_BLINK_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SLBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slbs implication check failed");

// next-cycle implication, sampled on clk, off during rst
`define SLBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slbs next-cycle check failed");

`endif

// ===== sv/slbs_pkg.sv =====
`default_nettype none

package slbs_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        countdown_active;
    logic [31:0] countdown_start;
    logic        distress_request;
    logic        gps_fix_valid;
    logic        battery_low;
    logic        airborne;
  } tick_t;

  typedef struct packed {
    logic        red_on;
    logic        green_on;
    logic        beep_start;
    logic [11:0] beep_tone_hz;
    logic [5:0]  beep_length_ms;
    logic        distress_trigger;
  } result_t;

  localparam logic [31:0] SOS_WINDOW_MS = 32'd60000;
  localparam int          REM_W         = 16;

  // floor(r / 75) = (r * BLINK_RECIP) >> BLINK_SHIFT for r <= 60000
  localparam logic [16:0] BLINK_RECIP   = 17'd111849;
  localparam int          BLINK_SHIFT   = 23;
  localparam int          BLINK_Q_W     = 10;
  // floor(r / 40) = (r * BEEP_RECIP) >> BEEP_SHIFT for r <= 60000
  localparam logic [16:0] BEEP_RECIP    = 17'd104858;
  localparam int          BEEP_SHIFT    = 22;
  localparam int          BEEP_Q_W      = 11;

  localparam logic [31:0] BLINK_BASE_MS = 32'd200;
  localparam logic [31:0] BEEP_BASE_MS  = 32'd500;
  localparam logic [31:0] T_200_MS      = 32'd200;
  localparam logic [31:0] T_500_MS      = 32'd500;
  localparam logic [31:0] T_800_MS      = 32'd800;
  localparam logic [31:0] T_1500_MS     = 32'd1500;
  localparam logic [31:0] T_2000_MS     = 32'd2000;

  localparam logic [11:0] TONE_COUNTDOWN = 12'd2000;
  localparam logic [11:0] TONE_DISTRESS  = 12'd3000;
  localparam logic [5:0]  LEN_COUNTDOWN  = 6'd30;
  localparam logic [5:0]  LEN_DISTRESS   = 6'd50;

  typedef struct packed {
    logic hold;
    logic take;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== sv/status_led_blink_sequencer_unit.sv =====
// status led blink sequencer
// tick channel: tick_valid / tick_ready with a tick_t beat holding the
// millisecond time, the countdown start and the status flags
// result channel: result_valid / result_ready with a result_t beat holding
// the red and green led levels, the beep request and the distress trigger
// one result beat per tick beat, in order
// path: a tick beat is held in the input register, passes through the
// blink and beep update and is loaded into the result register
// throughput: one beat per cycle unless result_ready stalls, set by the
// single blink and beep update between the input and result registers
// a tick beat is taken while a finished result still waits, as long as the
// input register is empty or moving on
// reset (rst, synchronous, active high) clears both valid flags, the blink
// and beep marks, the phase, both led levels and the sos latch
// a stall on result_ready holds the result register; one more tick beat is
// parked in the input register, then tick_ready drops
`default_nettype none

module status_led_blink_sequencer_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tick_valid,
  output logic                 tick_ready,
  input  wire slbs_pkg::tick_t tick,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output slbs_pkg::result_t    result
);
  import slbs_pkg::*;

  stage_ctl_t ctl;
  tick_t      held;
  result_t    next_result;
  logic       room;

  slbs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick       (tick),
    .room       (room),
    .ctl        (ctl),
    .held       (held)
  );

  slbs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (ctl.take),
    .tick   (held),
    .result (next_result)
  );

  slbs_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (ctl.take),
    .next_result  (next_result),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sv/slbs_in_reg.sv =====
`default_nettype none

module slbs_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tick_valid,
  output logic                tick_ready,
  input  wire slbs_pkg::tick_t tick,
  input  wire logic           room,
  output slbs_pkg::stage_ctl_t ctl,
  output slbs_pkg::tick_t     held
);
  import slbs_pkg::*;

  logic hold;

  assign ctl.hold   = hold;
  assign ctl.take   = hold && room;
  assign tick_ready = !hold || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (tick_valid && tick_ready) begin
      hold <= 1'b1;
    end else if (ctl.take) begin
      hold <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      held <= tick;
    end
  end

endmodule

`default_nettype wire

// ===== sv/slbs_core.sv =====
`default_nettype none

module slbs_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire slbs_pkg::tick_t tick,
  output slbs_pkg::result_t    result
);
  import slbs_pkg::*;

  `include "status_led_blink_sequencer_unit_assert.svh"

  logic [31:0] led_mark, led_mark_next;
  logic [31:0] beep_mark, beep_mark_next;
  logic        blink_phase, blink_phase_next;
  logic        red_level, red_level_next;
  logic        green_level, green_level_next;
  logic        sos_latched, sos_latched_next;

  logic [31:0] since_led, since_beep, elapsed;
  logic        sos_eff, expired;
  logic [REM_W-1:0] remaining;
  logic [32:0] blink_prod, beep_prod;
  logic [31:0] flash_limit, chirp_limit;
  logic        beep, trig;
  logic [11:0] tone;
  logic [5:0]  blen;

  assign since_led  = tick.now_ms - led_mark;
  assign since_beep = tick.now_ms - beep_mark;
  assign elapsed    = tick.now_ms - tick.countdown_start;
  assign expired    = elapsed >= SOS_WINDOW_MS;
  assign sos_eff    = tick.countdown_active && sos_latched;
  assign remaining  = SOS_WINDOW_MS[REM_W-1:0] - elapsed[REM_W-1:0];

  assign blink_prod  = 33'(remaining) * 33'(BLINK_RECIP);
  assign beep_prod   = 33'(remaining) * 33'(BEEP_RECIP);
  assign flash_limit = BLINK_BASE_MS + 32'(blink_prod[BLINK_SHIFT +: BLINK_Q_W]);
  assign chirp_limit = BEEP_BASE_MS + 32'(beep_prod[BEEP_SHIFT +: BEEP_Q_W]);

  always_comb begin
    led_mark_next    = led_mark;
    beep_mark_next   = beep_mark;
    blink_phase_next = blink_phase;
    red_level_next   = red_level;
    green_level_next = green_level;
    sos_latched_next = sos_eff;
    beep = 1'b0;
    trig = 1'b0;
    tone = '0;
    blen = '0;
    if (tick.countdown_active && !sos_latched) begin
      if (expired) begin
        sos_latched_next = 1'b1;
        trig             = 1'b1;
      end else begin
        if (since_led > flash_limit) begin
          blink_phase_next = !blink_phase;
          led_mark_next    = tick.now_ms;
          red_level_next   = !blink_phase;
          green_level_next = 1'b0;
        end
        if (since_beep > chirp_limit) begin
          beep_mark_next = tick.now_ms;
          beep = 1'b1;
          tone = TONE_COUNTDOWN;
          blen = LEN_COUNTDOWN;
        end
      end
    end else if (tick.distress_request || sos_eff) begin
      if (since_led > T_500_MS) begin
        blink_phase_next = !blink_phase;
        led_mark_next    = tick.now_ms;
        red_level_next   = !blink_phase;
        green_level_next = blink_phase;
      end
      if (since_beep > T_2000_MS) begin
        beep_mark_next = tick.now_ms;
        beep = 1'b1;
        tone = TONE_DISTRESS;
        blen = LEN_DISTRESS;
      end
    end else if (!tick.gps_fix_valid) begin
      if (!blink_phase && since_led > T_800_MS) begin
        blink_phase_next = 1'b1;
        led_mark_next    = tick.now_ms;
        red_level_next   = 1'b1;
        green_level_next = 1'b1;
      end else if (blink_phase && since_led > T_200_MS) begin
        blink_phase_next = 1'b0;
        led_mark_next    = tick.now_ms;
        red_level_next   = 1'b0;
        green_level_next = 1'b0;
      end
    end else if (tick.battery_low) begin
      if (!blink_phase && since_led > T_1500_MS) begin
        blink_phase_next = 1'b1;
        led_mark_next    = tick.now_ms;
        red_level_next   = 1'b1;
        green_level_next = 1'b0;
      end else if (blink_phase && since_led > T_500_MS) begin
        blink_phase_next = 1'b0;
        led_mark_next    = tick.now_ms;
        red_level_next   = 1'b0;
        green_level_next = 1'b1;
      end
    end else if (tick.airborne) begin
      red_level_next = 1'b0;
      if (!blink_phase && since_led > T_1500_MS) begin
        blink_phase_next = 1'b1;
        led_mark_next    = tick.now_ms;
        green_level_next = 1'b0;
      end else if (blink_phase && since_led > T_500_MS) begin
        blink_phase_next = 1'b0;
        led_mark_next    = tick.now_ms;
        green_level_next = 1'b1;
      end
    end else begin
      red_level_next   = 1'b0;
      green_level_next = 1'b1;
      blink_phase_next = 1'b0;
      led_mark_next    = tick.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_mark    <= '0;
      beep_mark   <= '0;
      blink_phase <= 1'b0;
      red_level   <= 1'b0;
      green_level <= 1'b0;
      sos_latched <= 1'b0;
    end else if (step) begin
      led_mark    <= led_mark_next;
      beep_mark   <= beep_mark_next;
      blink_phase <= blink_phase_next;
      red_level   <= red_level_next;
      green_level <= green_level_next;
      sos_latched <= sos_latched_next;
    end
  end

  assign result.red_on           = red_level_next;
  assign result.green_on         = green_level_next;
  assign result.beep_start       = beep;
  assign result.beep_tone_hz     = tone;
  assign result.beep_length_ms   = blen;
  assign result.distress_trigger = trig;

  `SLBS_ASSERT_IMP(a_trig_no_beep, step && trig, !beep)
  `SLBS_ASSERT_IMP(a_beep_tone, step && beep, tone == TONE_COUNTDOWN || tone == TONE_DISTRESS)
  `SLBS_ASSERT_NXT(a_trig_latches, step && trig, sos_latched)
  `SLBS_ASSERT_NXT(a_latch_clears, step && !tick.countdown_active, !sos_latched)

endmodule

`default_nettype wire

// ===== sv/slbs_out_reg.sv =====
`default_nettype none

module slbs_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire slbs_pkg::result_t next_result,
  output logic                   room,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output slbs_pkg::result_t      result
);
  import slbs_pkg::*;

  `include "status_led_blink_sequencer_unit_assert.svh"

  assign room = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_result;
    end
  end

  `SLBS_ASSERT_IMP(a_load_has_room, load, room)
  `SLBS_ASSERT_NXT(a_load_shows, load, result_valid)
  `SLBS_ASSERT_NXT(a_stall_keeps, result_valid && !result_ready && !load, $stable(result))

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import slbs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_TICKS = 1800;

  logic    clk;
  logic    rst = 1'b1;
  logic    tick_valid = 1'b0;
  logic    tick_ready;
  tick_t   tick = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      sent_count = 0;
  int      hold_cycles = 0;
  int      stall_left = 0;
  bit      idle_en = 1'b1;
  logic [31:0] now_cur = '0;

  // predicted blink and beep state
  logic [31:0] led_mark_q = '0;
  logic [31:0] beep_mark_q = '0;
  logic        phase_q = 1'b0;
  logic        red_q = 1'b0;
  logic        green_q = 1'b0;
  logic        sos_q = 1'b0;

  status_led_blink_sequencer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t blink_predict(input tick_t t);
    result_t     r;
    logic [31:0] since_led;
    logic [31:0] elapsed;
    logic [31:0] remaining;
    logic [31:0] period;
    logic [31:0] interval;
    r = '0;
    since_led = t.now_ms - led_mark_q;
    if (!t.countdown_active) sos_q = 1'b0;
    if (t.countdown_active && !sos_q) begin
      elapsed = t.now_ms - t.countdown_start;
      if (elapsed >= SOS_WINDOW_MS) begin
        sos_q = 1'b1;
        r.distress_trigger = 1'b1;
      end else begin
        remaining = SOS_WINDOW_MS - elapsed;
        period = BLINK_BASE_MS + (remaining * 32'd800) / SOS_WINDOW_MS;
        interval = BEEP_BASE_MS + (remaining * 32'd1500) / SOS_WINDOW_MS;
        if (since_led > period) begin
          phase_q = ~phase_q;
          led_mark_q = t.now_ms;
          red_q = phase_q;
          green_q = 1'b0;
        end
        if (t.now_ms - beep_mark_q > interval) begin
          beep_mark_q = t.now_ms;
          r.beep_start = 1'b1;
          r.beep_tone_hz = TONE_COUNTDOWN;
          r.beep_length_ms = LEN_COUNTDOWN;
        end
      end
    end else if (t.distress_request || sos_q) begin
      if (since_led > T_500_MS) begin
        phase_q = ~phase_q;
        led_mark_q = t.now_ms;
        red_q = phase_q;
        green_q = ~phase_q;
      end
      if (t.now_ms - beep_mark_q > T_2000_MS) begin
        beep_mark_q = t.now_ms;
        r.beep_start = 1'b1;
        r.beep_tone_hz = TONE_DISTRESS;
        r.beep_length_ms = LEN_DISTRESS;
      end
    end else if (!t.gps_fix_valid) begin
      if (!phase_q && since_led > T_800_MS) begin
        phase_q = 1'b1;
        led_mark_q = t.now_ms;
        red_q = 1'b1;
        green_q = 1'b1;
      end else if (phase_q && since_led > T_200_MS) begin
        phase_q = 1'b0;
        led_mark_q = t.now_ms;
        red_q = 1'b0;
        green_q = 1'b0;
      end
    end else if (t.battery_low) begin
      if (!phase_q && since_led > T_1500_MS) begin
        phase_q = 1'b1;
        led_mark_q = t.now_ms;
        red_q = 1'b1;
        green_q = 1'b0;
      end else if (phase_q && since_led > T_500_MS) begin
        phase_q = 1'b0;
        led_mark_q = t.now_ms;
        red_q = 1'b0;
        green_q = 1'b1;
      end
    end else if (t.airborne) begin
      red_q = 1'b0;
      if (!phase_q && since_led > T_1500_MS) begin
        phase_q = 1'b1;
        led_mark_q = t.now_ms;
        green_q = 1'b0;
      end else if (phase_q && since_led > T_500_MS) begin
        phase_q = 1'b0;
        led_mark_q = t.now_ms;
        green_q = 1'b1;
      end
    end else begin
      red_q = 1'b0;
      green_q = 1'b1;
      phase_q = 1'b0;
      led_mark_q = t.now_ms;
    end
    r.red_on = red_q;
    r.green_on = green_q;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_en) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic tick_t mk_tick(input logic [31:0] now, input logic active,
                                    input logic [31:0] start, input logic dreq,
                                    input logic fix, input logic batt, input logic air);
    tick_t t;
    t.now_ms = now;
    t.countdown_active = active;
    t.countdown_start = start;
    t.distress_request = dreq;
    t.gps_fix_valid = fix;
    t.battery_low = batt;
    t.airborne = air;
    return t;
  endfunction

  function automatic tick_t noise_tick();
    return mk_tick($urandom, 1'($urandom), $urandom, 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    pending_results.push_back(blink_predict(t));
    sent_count++;
  endtask

  task automatic wait_drain();
    tick_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // result beat checker
  always @(posedge clk) begin : check_results
    result_t e;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (result.red_on !== e.red_on || result.green_on !== e.green_on ||
            result.beep_start !== e.beep_start || result.beep_tone_hz !== e.beep_tone_hz ||
            result.beep_length_ms !== e.beep_length_ms ||
            result.distress_trigger !== e.distress_trigger)
          note_mismatch($sformatf(
            "exp red %b grn %b beep %b tone %0d len %0d trig %b, got %b %b %b %0d %0d %b",
            e.red_on, e.green_on, e.beep_start, e.beep_tone_hz, e.beep_length_ms,
            e.distress_trigger, result.red_on, result.green_on, result.beep_start,
            result.beep_tone_hz, result.beep_length_ms, result.distress_trigger));
      end
    end
  end

  // result receiver with random stalls and long hold-offs
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_modes();
    send_tick(mk_tick(32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd1600, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(32'd2200, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(32'd4000, 1'b0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_tick(mk_tick(32'd4600, 1'b0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_tick(mk_tick(32'd5500, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(32'd5800, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(32'd6400, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd6401, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd7000, 1'b1, 32'd7000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd9500, 1'b1, 32'd7000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd40000, 1'b1, 32'd7000, 1'b1, 1'b0, 1'b1, 1'b1));
    send_tick(mk_tick(32'd66999, 1'b1, 32'd7000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd67000, 1'b1, 32'd7000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd67100, 1'b1, 32'd7000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd67200, 1'b0, 32'd7000, 1'b0, 1'b1, 1'b0, 1'b0));
    // countdown start in the future expires at once
    send_tick(mk_tick(32'd67300, 1'b1, 32'd67301, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'd67400, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(32'd0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(32'd1000, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1));
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    now_cur = 32'd2000;
  endtask

  task automatic test_random_traffic();
    int          kind;
    int          n;
    int          target;
    logic [31:0] start;
    logic        dreq, fix, batt, air;
    tick_t       t;
    target = sent_count + RANDOM_TICKS;
    while (sent_count < target) begin
      kind = $urandom_range(0, 99);
      idle_en = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 19) == 0) now_cur = 32'hFFFF_0000 + $urandom_range(0, 60000);
      if (kind < 40) begin
        start = now_cur - $urandom_range(0, 2000);
        if ($urandom_range(0, 9) == 0) start = $urandom;
        n = 0;
        while ((now_cur - start) < 32'd61000 && n < 80) begin
          t = noise_tick();
          t.now_ms = now_cur;
          t.countdown_active = 1'b1;
          t.countdown_start = start;
          send_tick(t);
          n++;
          now_cur += $urandom_range(0, 2500);
        end
        repeat ($urandom_range(0, 6)) begin
          t = noise_tick();
          t.now_ms = now_cur;
          t.countdown_active = 1'b1;
          t.countdown_start = start;
          send_tick(t);
          now_cur += $urandom_range(0, 1200);
        end
        t = noise_tick();
        t.now_ms = now_cur;
        t.countdown_active = 1'b0;
        send_tick(t);
      end else if (kind < 95) begin
        dreq = ($urandom_range(0, 5) == 0);
        fix = ($urandom_range(0, 3) != 0);
        batt = ($urandom_range(0, 2) == 0);
        air = 1'($urandom);
        repeat ($urandom_range(5, 30)) begin
          send_tick(mk_tick(now_cur, 1'b0, $urandom, dreq, fix, batt, air));
          now_cur += $urandom_range(0, 1200);
        end
      end else begin
        repeat (3) begin
          t = noise_tick();
          send_tick(t);
          if ($urandom_range(0, 1)) now_cur = t.now_ms;
        end
      end
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tick_t t;
    idle_en = 1'b0;
    hold_cycles = 300;
    repeat (40) begin
      t = noise_tick();
      t.now_ms = now_cur;
      send_tick(t);
      now_cur += $urandom_range(0, 900);
    end
    idle_en = 1'b1;
    wait_drain();
  endtask

  task automatic test_drain_pause();
    tick_t t;
    repeat (2) begin
      repeat (20) begin
        t = noise_tick();
        t.now_ms = now_cur;
        send_tick(t);
        now_cur += $urandom_range(0, 900);
      end
      wait_drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_modes();
    test_backpressure();
    test_random_traffic();
    test_drain_pause();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
